FILE: design/wmslp_pkg.sv
// ----------------------------------------------------------------------------
// wmslp_pkg
// Types, codes and keyword constants shared by the modem status line parser.
// ----------------------------------------------------------------------------
package wmslp_pkg;

  localparam int WIN_LEN = 17;
  localparam int NUM_KW  = 12;

  // Input beat commands.
  typedef enum logic [1:0] {
    CMD_BYTE      = 2'd0,
    CMD_MQTT_UP   = 2'd1,
    CMD_MQTT_FAIL = 2'd2,
    CMD_TIMEOUT   = 2'd3
  } cmd_t;

  // Connection stages.
  localparam logic [1:0] STAGE_INIT = 2'd0;
  localparam logic [1:0] STAGE_WIFI = 2'd1;
  localparam logic [1:0] STAGE_TCP  = 2'd2;
  localparam logic [1:0] STAGE_MQTT = 2'd3;

  // Reconnect timer requests.
  localparam logic [1:0] REQ_NONE    = 2'd0;
  localparam logic [1:0] REQ_RESTART = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  // Characters of interest.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  // Keyword indexes into the hit vector.
  localparam int KW_GOTIP    = 0;
  localparam int KW_WCONN    = 1;
  localparam int KW_WDISC    = 2;
  localparam int KW_CWJAP    = 3;
  localparam int KW_CLOSED   = 4;
  localparam int KW_CFAIL    = 5;
  localparam int KW_ERROR    = 6;
  localparam int KW_ALREADY  = 7;
  localparam int KW_CCONNECT = 8;
  localparam int KW_LINKED   = 9;
  localparam int KW_FAIL     = 10;
  localparam int KW_IPD      = 11;

  // Keyword text, right-justified: the last character sits in the low byte.
  localparam logic [8*WIN_LEN-1:0] KW_TEXT [NUM_KW] = '{
    "GOT IP", "WIFI CONNECTED", "WIFI DISCONNECT", "+CWJAP:", "CLOSED",
    "CONNECT FAIL", "ERROR", "ALREADY CONNECTED", ",CONNECT", "LINKED",
    "FAIL", "+IPD"
  };
  localparam int KW_LEN [NUM_KW] = '{6, 14, 15, 7, 6, 12, 5, 17, 8, 6, 4, 4};

  // Parsed magnitude saturates here; enough to tell both clamp limits apart.
  localparam logic [7:0] MAG_SAT = 8'd129;

  // Window of recent text bytes, index 0 is the newest.
  typedef logic [WIN_LEN-1:0][7:0] win_t;

  // Per-byte control from the line tracker to the matcher and number parser.
  typedef struct packed {
    logic       step;   // a text byte is stored and matched
    logic       clear;  // line ends at this beat
    logic [7:0] data;
  } byte_ctl_t;

  // One status result.
  typedef struct packed {
    logic              wifi_up;
    logic              mqtt_up;
    logic              tcp_closed;
    logic signed [7:0] signal_dbm;
    logic [1:0]        stage_now;
    logic [1:0]        reconnect_request;
    logic              from_line;
  } status_t;

  // Compares every keyword against the tail of the window.
  function automatic logic [NUM_KW-1:0] kw_scan(input win_t w);
    logic [NUM_KW-1:0] hit;
    hit = '1;
    for (int k = 0; k < NUM_KW; k++) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        if (i < KW_LEN[k] && w[i] != KW_TEXT[k][8*i +: 8]) begin
          hit[k] = 1'b0;
        end
      end
    end
    return hit;
  endfunction

endpackage

FILE: design/wmslp_host_if.sv
// ----------------------------------------------------------------------------
// wmslp_host_if
// Input channel: modem bytes and link events with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wmslp_host_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

FILE: design/wmslp_status_if.sv
// ----------------------------------------------------------------------------
// wmslp_status_if
// Output channel: link status results with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wmslp_status_if;
  logic              valid;
  logic              ready;
  logic              wifi_up;
  logic              mqtt_up;
  logic              tcp_closed;
  logic signed [7:0] signal_dbm;
  logic [1:0]        stage_now;
  logic [1:0]        reconnect_request;
  logic              from_line;

  modport source (output valid, output wifi_up, output mqtt_up, output tcp_closed,
                  output signal_dbm, output stage_now, output reconnect_request,
                  output from_line, input ready);
  modport sink   (input valid, input wifi_up, input mqtt_up, input tcp_closed,
                  input signal_dbm, input stage_now, input reconnect_request,
                  input from_line, output ready);
endinterface

FILE: design/wmslp_match.sv
// ----------------------------------------------------------------------------
// wmslp_match
// Sliding window of recent text bytes and the per-line keyword hit bits.
// ----------------------------------------------------------------------------
module wmslp_match
  import wmslp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  byte_ctl_t         ctl,
  output logic [NUM_KW-1:0] hits,
  output logic [NUM_KW-1:0] hits_line
);

  win_t              win;
  win_t              win_next;
  logic [NUM_KW-1:0] hits_next;

  assign win_next  = {win[WIN_LEN-2:0], ctl.data};
  assign hits_next = hits | kw_scan(win_next);
  // Hits including the current beat, as seen when the line ends here.
  assign hits_line = ctl.step ? hits_next : hits;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      win  <= '0;
      hits <= '0;
    end else if (ctl.step) begin
      win  <= win_next;
      hits <= hits_next;
    end
  end

endmodule

FILE: design/wmslp_num.sv
// ----------------------------------------------------------------------------
// wmslp_num
// Signal strength number parser: space skip, sign, digits, saturation.
// ----------------------------------------------------------------------------
module wmslp_num
  import wmslp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  byte_ctl_t         ctl,
  input  logic              cwjap_seen,
  output logic              parsed,
  output logic signed [7:0] value
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_SKIP = 4'b0010,
    PH_NUM  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic        neg;
  logic        neg_next;
  logic [7:0]  mag;
  logic [7:0]  mag_next;
  logic [10:0] mag_acc;
  logic        is_digit;
  logic        is_space;

  assign is_digit = ctl.data >= CHAR_0 && ctl.data <= CHAR_9;
  assign is_space = ctl.data inside {[CHAR_TAB:CHAR_CR], CHAR_SP};
  assign mag_acc  = {3'b000, mag} * 11'd10 + {7'd0, ctl.data[3:0]};

  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    mag_next   = mag;
    if (ctl.step) begin
      // A comma after the join keyword restarts the number.
      if (ctl.data == CHAR_COMMA && cwjap_seen) begin
        phase_next = PH_SKIP;
        neg_next   = 1'b0;
        mag_next   = '0;
      end else begin
        case (phase)
          PH_SKIP: begin
            if (ctl.data == CHAR_PLUS || ctl.data == CHAR_MINUS) begin
              neg_next   = ctl.data == CHAR_MINUS;
              phase_next = PH_NUM;
            end else if (is_digit) begin
              mag_next   = {4'd0, ctl.data[3:0]};
              phase_next = PH_NUM;
            end else if (!is_space) begin
              phase_next = PH_DONE;
            end
          end
          PH_NUM: begin
            if (is_digit) begin
              mag_next = (mag_acc > 11'(MAG_SAT)) ? MAG_SAT : mag_acc[7:0];
            end else begin
              phase_next = PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign parsed = phase_next != PH_IDLE;

  always_comb begin
    if (neg_next) begin
      value = (mag_next > 8'd128) ? -8'sd128 : signed'(8'(9'd0 - {1'b0, mag_next}));
    end else begin
      value = (mag_next > 8'd127) ? 8'sd127 : signed'(mag_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      phase <= PH_IDLE;
      neg   <= 1'b0;
      mag   <= '0;
    end else begin
      phase <= phase_next;
      neg   <= neg_next;
      mag   <= mag_next;
    end
  end

endmodule

FILE: design/wifi_modem_status_line_parser_unit.sv
// ----------------------------------------------------------------------------
// wifi_modem_status_line_parser_unit
// Gathers modem response lines, matches status keywords and link events,
// and reports the resulting wifi, mqtt and tcp status.
// ----------------------------------------------------------------------------
// Path: an accepted beat goes through the input register, then the result register.
// Throughput: one beat per cycle unless the status side stalls; the window compare,
// number parser and status rules all fit between the input and result registers.
// Reset: synchronous; clears all flags, the line state and both valid bits.
// ----------------------------------------------------------------------------
module wifi_modem_status_line_parser_unit
  import wmslp_pkg::*;
#(
  parameter int LINE_MAX = 1023
)
(
  input  logic           clk,
  input  logic           rst,
  wmslp_host_if.sink     host,
  wmslp_status_if.source status
);

  localparam int LEN_W = $clog2(LINE_MAX + 1);

  // Input register.
  logic       hold_valid;
  cmd_t       hold_cmd;
  logic [7:0] hold_byte;

  // Result register.
  logic    res_valid;
  status_t res;

  // Line state.
  logic [LEN_W-1:0] line_length;
  logic             text_ended;
  logic             has_text;

  // Link state.
  logic              wifi_flag, mqtt_flag, closed_flag;
  logic signed [7:0] rssi_value;
  logic [1:0]        stage_reg;

  logic              wifi_next, mqtt_next, closed_next;
  logic signed [7:0] rssi_next;
  logic [1:0]        stage_next;
  logic [1:0]        req;
  logic              emit;
  logic              line_done;

  logic              slot_free;
  logic              proc;
  logic              is_byte;
  logic              store;
  logic              has_text_line;
  byte_ctl_t         ctl;
  logic [NUM_KW-1:0] hits;
  logic [NUM_KW-1:0] hits_line;
  logic              num_parsed;
  logic signed [7:0] num_value;

  assign slot_free  = !res_valid || status.ready;
  assign proc       = hold_valid && slot_free;
  assign host.ready = !hold_valid || slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (host.ready) begin
      hold_valid <= host.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (host.valid && host.ready) begin
      hold_cmd  <= cmd_t'(host.cmd);
      hold_byte <= host.rx_byte;
    end
  end

  // Bytes beyond the line limit are dropped, but a newline still ends the line.
  assign is_byte       = proc && hold_cmd == CMD_BYTE;
  assign store         = is_byte && line_length < LEN_W'(LINE_MAX);
  assign ctl.step      = store && !text_ended && hold_byte != CHAR_NUL;
  assign ctl.clear     = is_byte && hold_byte == CHAR_LF;
  assign ctl.data      = hold_byte;
  assign has_text_line = has_text || ctl.step;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      line_length <= '0;
      text_ended  <= 1'b0;
      has_text    <= 1'b0;
    end else if (store) begin
      line_length <= line_length + 1'b1;
      if (!text_ended && hold_byte == CHAR_NUL) begin
        text_ended <= 1'b1;
      end
      if (ctl.step) begin
        has_text <= 1'b1;
      end
    end
  end

  wmslp_match u_match (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .hits      (hits),
    .hits_line (hits_line)
  );

  wmslp_num u_num (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cwjap_seen (hits[KW_CWJAP]),
    .parsed     (num_parsed),
    .value      (num_value)
  );

  // Status rules; at line end later rules override earlier ones.
  always_comb begin
    wifi_next   = wifi_flag;
    mqtt_next   = mqtt_flag;
    closed_next = closed_flag;
    rssi_next   = rssi_value;
    stage_next  = stage_reg;
    req         = REQ_NONE;
    emit        = 1'b0;
    line_done   = 1'b0;
    if (proc) begin
      case (hold_cmd)
        CMD_MQTT_UP: begin
          mqtt_next  = 1'b1;
          stage_next = STAGE_MQTT;
          emit       = 1'b1;
        end
        CMD_MQTT_FAIL: begin
          mqtt_next   = 1'b0;
          closed_next = 1'b1;
          emit        = 1'b1;
        end
        CMD_TIMEOUT: begin
          wifi_next   = 1'b0;
          mqtt_next   = 1'b0;
          closed_next = 1'b1;
          stage_next  = STAGE_INIT;
          req         = REQ_CLEAR;
          emit        = 1'b1;
        end
        CMD_BYTE: begin
          if (ctl.clear && has_text_line) begin
            emit      = 1'b1;
            line_done = 1'b1;
            if (hits_line[KW_GOTIP]) begin
              wifi_next  = 1'b1;
              stage_next = STAGE_WIFI;
              req        = REQ_RESTART;
            end else if (hits_line[KW_WCONN]) begin
              wifi_next  = 1'b1;
              stage_next = STAGE_WIFI;
            end
            if (hits_line[KW_WDISC]) begin
              wifi_next   = 1'b0;
              mqtt_next   = 1'b0;
              closed_next = 1'b1;
              stage_next  = STAGE_INIT;
              req         = REQ_CLEAR;
            end
            if (hits_line[KW_CWJAP]) begin
              if (num_parsed) begin
                rssi_next = num_value;
              end
              wifi_next  = 1'b1;
              stage_next = STAGE_WIFI;
            end
            if (hits_line[KW_CLOSED] || hits_line[KW_CFAIL] || hits_line[KW_ERROR]) begin
              mqtt_next   = 1'b0;
              closed_next = 1'b1;
              if (stage_next inside {STAGE_TCP, STAGE_MQTT}) begin
                stage_next = STAGE_WIFI;
              end
            end
            if ((hits_line[KW_ALREADY] || hits_line[KW_CCONNECT] || hits_line[KW_LINKED])
                && !(hits_line[KW_FAIL] || hits_line[KW_ERROR])) begin
              closed_next = 1'b0;
              stage_next  = STAGE_TCP;
            end
            if (hits_line[KW_IPD]) begin
              closed_next = 1'b0;
              if (stage_next inside {STAGE_INIT, STAGE_WIFI}) begin
                stage_next = STAGE_TCP;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wifi_flag   <= 1'b0;
      mqtt_flag   <= 1'b0;
      closed_flag <= 1'b0;
      rssi_value  <= '0;
      stage_reg   <= STAGE_INIT;
    end else begin
      wifi_flag   <= wifi_next;
      mqtt_flag   <= mqtt_next;
      closed_flag <= closed_next;
      rssi_value  <= rssi_next;
      stage_reg   <= stage_next;
    end
  end

  // The result register refills or empties whenever its slot frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (slot_free) begin
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit) begin
      res.wifi_up           <= wifi_next;
      res.mqtt_up           <= mqtt_next;
      res.tcp_closed        <= closed_next;
      res.signal_dbm        <= rssi_next;
      res.stage_now         <= stage_next;
      res.reconnect_request <= req;
      res.from_line         <= line_done;
    end
  end

  assign status.valid             = res_valid;
  assign status.wifi_up           = res.wifi_up;
  assign status.mqtt_up           = res.mqtt_up;
  assign status.tcp_closed        = res.tcp_closed;
  assign status.signal_dbm        = res.signal_dbm;
  assign status.stage_now         = res.stage_now;
  assign status.reconnect_request = res.reconnect_request;
  assign status.from_line         = res.from_line;

  // A timer restart only comes from a line that leaves wifi up.
  a_restart_wifi: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.reconnect_request == REQ_RESTART |-> res.wifi_up && res.from_line)
    else $error("restart request without wifi up");

  // An event that clears the timer is the link timeout, which drops everything.
  a_timeout_state: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.from_line && res.reconnect_request == REQ_CLEAR
      |-> !res.wifi_up && !res.mqtt_up && res.tcp_closed && res.stage_now == STAGE_INIT)
    else $error("timeout result with inconsistent status");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_W'(LINE_MAX))
    else $error("line length past limit");

  // Text can only end on a stored byte.
  a_ended_len: assert property (@(posedge clk) disable iff (rst)
    text_ended |-> line_length != '0)
    else $error("text ended on an empty line");

  // A stalled result must not be overwritten.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !status.ready |=> res_valid && $stable(res))
    else $error("pending result changed");

endmodule

FILE: bench/wmslp_status_checker.sv
// ----------------------------------------------------------------------------
// wmslp_status_checker
// Watches both channels of the modem status line parser. It keeps its own
// copy of the link flags and the line state, and works out the status beat
// that each accepted host beat should cause. It then compares every
// accepted status beat, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module wmslp_status_checker
  import wmslp_pkg::*;
#(
  parameter int LINE_MAX = 1023
)
(
  input  logic     clk,
  input  logic     rst,
  wmslp_host_if    host,
  wmslp_status_if  status,
  input  logic     end_check,
  output int       fail_count,
  output int       results_owed
);

  typedef enum logic [1:0] {
    NUM_IDLE,
    NUM_SKIP,
    NUM_DIGITS,
    NUM_DONE
  } num_phase_t;

  // Order follows the KW_* hit indexes.
  string keywords [NUM_KW] = '{
    "GOT IP", "WIFI CONNECTED", "WIFI DISCONNECT", "+CWJAP:", "CLOSED",
    "CONNECT FAIL", "ERROR", "ALREADY CONNECTED", ",CONNECT", "LINKED",
    "FAIL", "+IPD"
  };

  logic              link_wifi, link_mqtt, link_closed;
  logic signed [7:0] link_dbm;
  logic [1:0]        link_stage;

  logic [7:0]        tail [WIN_LEN];  // tail[WIN_LEN-1] is the newest byte
  logic [NUM_KW-1:0] hits;
  int                line_len;
  bit                text_done, text_seen;
  num_phase_t        num_phase;
  bit                num_neg;
  int                num_mag;

  status_t           due_status [$];
  int                errors = 0;
  int                owed = 0;
  bit                leftovers_checked = 0;

  assign fail_count   = errors;
  assign results_owed = owed;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic bit is_blank(input logic [7:0] c);
    return c == CHAR_SP || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CHAR_0 && c <= CHAR_9;
  endfunction

  task automatic clear_line();
    foreach (tail[i]) tail[i] = 8'h00;
    hits      = '0;
    line_len  = 0;
    text_done = 0;
    text_seen = 0;
    num_phase = NUM_IDLE;
    num_neg   = 0;
    num_mag   = 0;
  endtask

  task automatic push_status(input logic [1:0] req, input logic line_done);
    status_t s;
    s.wifi_up           = link_wifi;
    s.mqtt_up           = link_mqtt;
    s.tcp_closed        = link_closed;
    s.signal_dbm        = link_dbm;
    s.stage_now         = link_stage;
    s.reconnect_request = req;
    s.from_line         = line_done;
    due_status.push_back(s);
  endtask

  // A comma after the join keyword (re)starts the number; the hit is the one
  // from bytes before this one.
  task automatic step_number(input logic [7:0] c);
    if (c == CHAR_COMMA && hits[KW_CWJAP]) begin
      num_phase = NUM_SKIP;
      num_neg   = 0;
      num_mag   = 0;
    end else if (num_phase == NUM_SKIP) begin
      if (!is_blank(c)) begin
        if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          num_neg   = (c == CHAR_MINUS);
          num_phase = NUM_DIGITS;
        end else if (is_digit(c)) begin
          num_mag   = c - CHAR_0;
          num_phase = NUM_DIGITS;
        end else begin
          num_phase = NUM_DONE;
        end
      end
    end else if (num_phase == NUM_DIGITS) begin
      if (is_digit(c)) begin
        num_mag = num_mag * 10 + (c - CHAR_0);
        if (num_mag > 129) num_mag = 129;
      end else begin
        num_phase = NUM_DONE;
      end
    end
  endtask

  task automatic shift_and_match(input logic [7:0] c);
    int  len;
    bit  ok;
    for (int i = 0; i < WIN_LEN - 1; i++) tail[i] = tail[i + 1];
    tail[WIN_LEN - 1] = c;
    for (int k = 0; k < NUM_KW; k++) begin
      len = keywords[k].len();
      ok  = 1;
      for (int i = 0; i < len; i++) begin
        if (tail[WIN_LEN - len + i] != keywords[k][i]) ok = 0;
      end
      if (ok) hits[k] = 1'b1;
    end
  endtask

  task automatic close_line();
    logic [NUM_KW-1:0] h;
    logic [1:0]        req;
    bit                parsed, seen;
    int                val;
    h      = hits;
    req    = REQ_NONE;
    parsed = (num_phase != NUM_IDLE);
    seen   = text_seen;
    if (num_neg) val = -((num_mag > 128) ? 128 : num_mag);
    else         val = (num_mag > 127) ? 127 : num_mag;
    clear_line();
    if (seen) begin
      if (h[KW_GOTIP]) begin
        link_wifi = 1; link_stage = STAGE_WIFI; req = REQ_RESTART;
      end else if (h[KW_WCONN]) begin
        link_wifi = 1; link_stage = STAGE_WIFI;
      end
      if (h[KW_WDISC]) begin
        link_wifi = 0; link_mqtt = 0; link_closed = 1;
        link_stage = STAGE_INIT; req = REQ_CLEAR;
      end
      if (h[KW_CWJAP]) begin
        if (parsed) link_dbm = val[7:0];
        link_wifi = 1; link_stage = STAGE_WIFI;
      end
      if (h[KW_CLOSED] || h[KW_CFAIL] || h[KW_ERROR]) begin
        link_mqtt = 0; link_closed = 1;
        if (link_stage >= STAGE_TCP) link_stage = STAGE_WIFI;
      end
      if ((h[KW_ALREADY] || h[KW_CCONNECT] || h[KW_LINKED]) &&
          !(h[KW_FAIL] || h[KW_ERROR])) begin
        link_closed = 0; link_stage = STAGE_TCP;
      end
      if (h[KW_IPD]) begin
        link_closed = 0;
        if (link_stage < STAGE_TCP) link_stage = STAGE_TCP;
      end
      push_status(req, 1'b1);
    end
  endtask

  task automatic apply_host_beat(input cmd_t op, input logic [7:0] c);
    case (op)
      CMD_MQTT_UP: begin
        link_mqtt = 1; link_stage = STAGE_MQTT;
        push_status(REQ_NONE, 1'b0);
      end
      CMD_MQTT_FAIL: begin
        link_mqtt = 0; link_closed = 1;
        push_status(REQ_NONE, 1'b0);
      end
      CMD_TIMEOUT: begin
        link_wifi = 0; link_mqtt = 0; link_closed = 1; link_stage = STAGE_INIT;
        push_status(REQ_CLEAR, 1'b0);
      end
      default: begin
        // Bytes past LINE_MAX are dropped, but a newline still ends the line.
        if (line_len < LINE_MAX) begin
          line_len++;
          if (!text_done) begin
            if (c == CHAR_NUL) begin
              text_done = 1;
            end else begin
              text_seen = 1;
              step_number(c);
              shift_and_match(c);
            end
          end
        end
        if (c == CHAR_LF) close_line();
      end
    endcase
  endtask

  task automatic check_status_beat();
    status_t want;
    if (due_status.size() == 0) begin
      report_mismatch("status beat with nothing outstanding, stage_now",
                      status.stage_now, -1);
    end else begin
      want = due_status.pop_front();
      if (status.wifi_up !== want.wifi_up)
        report_mismatch("wifi_up", status.wifi_up, want.wifi_up);
      if (status.mqtt_up !== want.mqtt_up)
        report_mismatch("mqtt_up", status.mqtt_up, want.mqtt_up);
      if (status.tcp_closed !== want.tcp_closed)
        report_mismatch("tcp_closed", status.tcp_closed, want.tcp_closed);
      if (status.signal_dbm !== want.signal_dbm)
        report_mismatch("signal_dbm", status.signal_dbm, want.signal_dbm);
      if (status.stage_now !== want.stage_now)
        report_mismatch("stage_now", status.stage_now, want.stage_now);
      if (status.reconnect_request !== want.reconnect_request)
        report_mismatch("reconnect_request", status.reconnect_request,
                        want.reconnect_request);
      if (status.from_line !== want.from_line)
        report_mismatch("from_line", status.from_line, want.from_line);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      link_wifi   = 0;
      link_mqtt   = 0;
      link_closed = 0;
      link_dbm    = '0;
      link_stage  = STAGE_INIT;
      clear_line();
      due_status.delete();
    end else begin
      if (host.valid && host.ready) apply_host_beat(cmd_t'(host.cmd), host.rx_byte);
      if (status.valid && status.ready) check_status_beat();
      if (end_check && !leftovers_checked) begin
        leftovers_checked = 1;
        if (due_status.size() != 0)
          report_mismatch("status beats never delivered", 0, due_status.size());
      end
    end
    owed <= due_status.size();
  end

endmodule

FILE: bench/tb_wifi_modem_status_line_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_wifi_modem_status_line_parser_unit
// Drives modem lines and link events into the status line parser: a directed
// pass over every keyword rule, number corner and line corner, then random
// lines built from keywords, numbers and noise. Both sides idle in random
// bursts, and the status side holds off once for a long stretch. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_wifi_modem_status_line_parser_unit
  import wmslp_pkg::*;
();

  localparam int LINE_MAX       = 1023;
  localparam int ITEMS          = 950;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_PHRASES    = 18;

  logic clk = 1'b0;
  logic rst;
  logic end_check;
  int   fail_count;
  int   results_owed;

  bit   gaps_on = 1;
  int   hold_req = 0;
  int   beats_sent = 0;
  int   quiet_cycles = 0;

  // Keywords plus near misses that should not hit, and phrases that hold a keyword.
  string phrases [NUM_PHRASES] = '{
    "GOT IP", "WIFI CONNECTED", "WIFI DISCONNECT", "+CWJAP:", "CLOSED",
    "CONNECT FAIL", "ERROR", "ALREADY CONNECTED", ",CONNECT", "LINKED",
    "FAIL", "+IPD", "OK", "0,CONNECT", "+CWJAP", "GOT I", "WIFI GOT IP",
    "+IPD,0,4:"
  };

  wmslp_host_if   host ();
  wmslp_status_if status ();

  wifi_modem_status_line_parser_unit #(.LINE_MAX(LINE_MAX)) dut (
    .clk    (clk),
    .rst    (rst),
    .host   (host),
    .status (status)
  );

  wmslp_status_checker #(.LINE_MAX(LINE_MAX)) status_check (
    .clk          (clk),
    .rst          (rst),
    .host         (host),
    .status       (status),
    .end_check    (end_check),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (host.valid && host.ready) || (status.valid && status.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_wifi_modem_status_line_parser_unit: FAIL");
      $finish;
    end
  end

  // Status side: ready in random runs, random stall bursts, and one long
  // hold-off when the stimulus asks for it.
  initial begin
    int n;
    status.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        status.ready <= 1'b0;
        for (n = 0; n < hold_req; n++) @(posedge clk);
        hold_req = 0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        status.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        status.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input cmd_t op, input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 6) == 0) begin
      host.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    host.valid   <= 1'b1;
    host.cmd     <= op;
    host.rx_byte <= b;
    @(posedge clk);
    while (!host.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(CMD_BYTE, s[i]);
  endtask

  task automatic send_event();
    send_beat(cmd_t'($urandom_range(1, 3)), 8'($urandom));
  endtask

  // Leading blanks, an optional sign, then digits that often run past the
  // clamp limits; now and then no digits at all.
  task automatic send_number();
    string blanks;
    blanks = " \t\r\013\014";
    repeat ($urandom_range(0, 2)) send_beat(CMD_BYTE, blanks[$urandom_range(0, 4)]);
    case ($urandom_range(0, 3))
      0: send_beat(CMD_BYTE, CHAR_MINUS);
      1: send_beat(CMD_BYTE, CHAR_PLUS);
      default: ;
    endcase
    if ($urandom_range(0, 7) != 0) begin
      if ($urandom_range(0, 1) == 0) send_text($sformatf("%0d", $urandom_range(0, 200)));
      else send_text($sformatf("%0d", $urandom_range(0, 99999)));
    end
  endtask

  task automatic send_random_line();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4: send_text(phrases[$urandom_range(0, NUM_PHRASES - 1)]);
        5, 6: begin
          send_text("+CWJAP:\"lab\",\"aa:bb\",11,");
          send_number();
        end
        7: begin
          send_beat(CMD_BYTE, CHAR_COMMA);
          send_number();
        end
        8: send_text(" ");
        9: send_beat(CMD_BYTE, 8'($urandom_range(1, 255)));
        10: begin
          if ($urandom_range(0, 3) == 0) send_beat(CMD_BYTE, CHAR_NUL);
          else send_text(":");
        end
        default: send_event();
      endcase
    end
    send_beat(CMD_BYTE, CHAR_LF);
  endtask

  initial begin
    bit pressure_done;
    pressure_done = 0;
    rst          <= 1'b1;
    end_check    <= 1'b0;
    host.valid   <= 1'b0;
    host.cmd     <= CMD_BYTE;
    host.rx_byte <= CHAR_NUL;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Events first: timeout while wifi is already down, ignored byte all ones.
    send_beat(CMD_TIMEOUT, 8'hFF);
    send_text("GOT IP\n");
    send_text("WIFI CONNECTED\n");
    send_beat(CMD_MQTT_UP, 8'h00);
    send_text("+CWJAP:\"ap\",\"00:11\",6, -67\n");
    send_text("+CWJAP:,+300\n");
    send_text("+CWJAP:,-129\n");
    send_text("+CWJAP:,-128\n");
    send_text("+CWJAP:,127\n");
    send_text("+CWJAP:,x9\n");
    send_text("+CWJAP:\n");
    send_text(",5+CWJAP:9\n");
    send_text("+CWJAP:,\t\013\014\r 5,-7z\n");
    send_text("CLOSED\n");
    send_beat(CMD_MQTT_FAIL, 8'h55);
    send_text("CONNECT FAIL\n");
    send_text("ERROR\n");
    send_text("ALREADY CONNECTED\n");
    send_text("0,CONNECT\n");
    send_text("LINKED\n");
    send_text("ALREADY CONNECTED FAIL\n");
    send_text("+IPD,5:hello\n");
    send_text("WIFI DISCONNECT\n");
    send_text("\n");
    // A zero byte first leaves the text empty: no status beat.
    send_beat(CMD_BYTE, CHAR_NUL);
    send_text("GOT IP\n");
    send_text("GOT");
    send_beat(CMD_BYTE, CHAR_NUL);
    send_text(" IP\n");
    send_text("GOT IP");
    send_beat(CMD_BYTE, CHAR_NUL);
    send_text("x\n");
    send_text("GOT ");
    send_beat(CMD_MQTT_UP, 8'hAA);
    send_text("IP\n");
    // Overlong lines: one that just fits the keyword, one that cuts it.
    repeat (LINE_MAX - 6) send_beat(CMD_BYTE, 8'($urandom_range(32, 126)));
    send_text("GOT IP\n");
    repeat (LINE_MAX - 3) send_beat(CMD_BYTE, 8'($urandom_range(32, 126)));
    send_text("GOT IP\n");

    beats_sent = 0;
    while (beats_sent < ITEMS) begin
      if (!pressure_done && beats_sent >= ITEMS / 2) begin
        // Hold the status side off and keep offering events until the
        // block backs up into the host side.
        pressure_done = 1;
        hold_req = HOLD_CYCLES;
        repeat (24) send_event();
      end
      if (beats_sent >= ITEMS - 150) gaps_on = 0;
      case ($urandom_range(0, 19))
        0, 1, 2: send_event();
        3, 4: begin
          repeat ($urandom_range(0, 20)) send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
          send_beat(CMD_BYTE, CHAR_LF);
        end
        default: send_random_line();
      endcase
    end
    host.valid <= 1'b0;

    while (results_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    end_check <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_wifi_modem_status_line_parser_unit: PASS");
    end else begin
      $display("tb_wifi_modem_status_line_parser_unit: FAIL");
    end
    $finish;
  end

endmodule
